@@ rtl/ste_pkg.sv @@
// Shared types and constants for the sorted table with insert, erase and read.
package ste_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_W       = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_ERASE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                     kind;
    logic signed [VALUE_WIDTH-1:0]  value;
    logic [POS_W-1:0]               position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                     status;
    logic signed [VALUE_WIDTH-1:0]  read_value;
    logic [CNT_W-1:0]               entry_count;
  } out_item_t;

  typedef struct packed {
    logic                           ins_en;
    logic                           ers_en;
    logic signed [VALUE_WIDTH-1:0]  value;
  } cell_ctl_t;

endpackage

@@ rtl/ste_cell.sv @@
// One table cell: holds an entry, compares it with the operand and shifts.
module ste_cell (
  input  logic                                   clk,
  input  ste_pkg::cell_ctl_t                     ctl,
  input  logic                                   valid,
  input  logic                                   left_lt,
  input  logic signed [ste_pkg::VALUE_WIDTH-1:0] left_val,
  input  logic signed [ste_pkg::VALUE_WIDTH-1:0] right_val,
  output logic signed [ste_pkg::VALUE_WIDTH-1:0] val,
  output logic                                   lt,
  output logic                                   eq
);
  import ste_pkg::*;

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] val_nxt;

  assign lt  = valid && (val_r < ctl.value);
  assign eq  = valid && (val_r == ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && !lt) begin
      val_nxt = left_lt ? ctl.value : left_val;
    end else if (ctl.ers_en && !lt) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ rtl/sorted_table_insert_erase.sv @@
// Top level: a row of sorted cells with count tracking and a registered result.
// The result of an item is registered and shown in the cycle after the item is accepted.
// Throughput: one item per cycle while the input is not stalled; every cell compares and shifts in that same cycle.
// The input stalls only while a finished result waits on a stalled output.
// Reset clears the entry count and the output valid; entry storage is not cleared.
module sorted_table_insert_erase (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ste_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ste_pkg::out_item_t out_item
);
  import ste_pkg::*;

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic                          out_valid_r;
  out_item_t                     out_item_r;
  out_item_t                     out_item_nxt;
  logic                          in_acc;
  logic                          full;
  logic                          found;
  logic                          pos_ok;
  cell_ctl_t                     ctl;
  logic [CAPACITY-1:0]           cell_valid;
  logic [CAPACITY-1:0]           cell_lt;
  logic [CAPACITY-1:0]           cell_eq;
  logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r >= CNT_W'(CAPACITY));
  assign found    = |cell_eq;
  assign pos_ok   = ({1'b0, in_item.position} < CNT_W'(count_r));

  always_comb begin
    ctl.value  = in_item.value;
    ctl.ins_en = in_acc && (in_item.kind == KIND_INSERT) && !full;
    ctl.ers_en = in_acc && (in_item.kind == KIND_ERASE) && found;
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic                          l_lt;
      logic signed [VALUE_WIDTH-1:0] l_val;
      logic signed [VALUE_WIDTH-1:0] r_val;

      assign cell_valid[g] = (CNT_W'(g) < count_r);

      if (g == 0) begin : g_first
        assign l_lt  = 1'b1;
        assign l_val = in_item.value;
      end else begin : g_mid
        assign l_lt  = cell_lt[g-1];
        assign l_val = cell_val[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign r_val = cell_val[g];
      end else begin : g_inner
        assign r_val = cell_val[g+1];
      end

      ste_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (cell_valid[g]),
        .left_lt   (l_lt),
        .left_val  (l_val),
        .right_val (r_val),
        .val       (cell_val[g]),
        .lt        (cell_lt[g]),
        .eq        (cell_eq[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt                = count_r;
    out_item_nxt.status      = ST_OK;
    out_item_nxt.read_value  = '0;
    case (kind_t'(in_item.kind))
      KIND_INSERT: begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_ERASE: begin
        if (found) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          out_item_nxt.status = ST_NOT_FOUND;
        end
      end
      KIND_READ: begin
        if (pos_ok) begin
          out_item_nxt.read_value = cell_val[in_item.position];
        end else begin
          out_item_nxt.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    out_item_nxt.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_lt[CAPACITY-1:1] & ~cell_lt[CAPACITY-2:0]) == '0)
    else $error("less-than flags do not form a prefix");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_item.kind == KIND_INSERT) && !full
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.status == ST_FULL)
    |-> out_item_r.entry_count == CNT_W'(CAPACITY))
    else $error("full status with table not full");

endmodule
